@@ hdl/slm_pkg.sv @@
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types, constants and helpers of the substring match locator.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned COUNT_WIDTH = 32;
   localparam int unsigned LEN_WIDTH   = 5;
   localparam int unsigned CSR_WIDTH   = 64;
   localparam int unsigned CSR_IDX_WIDTH = 2;
   localparam int unsigned TERM_WIDTH  = 2 * CSR_WIDTH;
   localparam int unsigned TERM_BYTES  = TERM_WIDTH / BYTE_WIDTH;

   localparam logic [BYTE_WIDTH-1:0]  NEWLINE_BYTE = 8'h0A;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = 32'hFFFF_FFFF;
   localparam logic [COUNT_WIDTH-1:0] FIRST_LINE   = 32'd1;
   localparam logic [LEN_WIDTH-1:0]   LEN_RESET    = 5'd1;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TERM_LENGTH     = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TERM_BYTES_LOW  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_TERM_BYTES_HIGH = 2'd2;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  file_end;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] match_line;
      logic [COUNT_WIDTH-1:0] match_column;
      logic                   match_last;
   } rsp_payload_type;

   // one window slot as it moves down the chain
   typedef struct packed {
      logic                   valid;
      logic [BYTE_WIDTH-1:0]  data_byte;
      logic [COUNT_WIDTH-1:0] line;
      logic [COUNT_WIDTH-1:0] column;
   } cell_link_type;

   // position of the match start, reported by the selected cell
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] line;
      logic [COUNT_WIDTH-1:0] column;
   } match_pos_type;

   // term byte k, zero beyond the two registers
   function automatic logic [BYTE_WIDTH-1:0] term_byte(
      input logic [TERM_WIDTH-1:0] term,
      input logic [LEN_WIDTH-1:0]  k
   );
      logic [BYTE_WIDTH-1:0] b;
      if (k[LEN_WIDTH-1]) begin
         b = '0;
      end else begin
         b = term[{k[LEN_WIDTH-2:0], 3'b000} +: BYTE_WIDTH];
      end
      return b;
   endfunction

endpackage

@@ hdl/slm_cell.sv @@
// ----------------------------------------------------------------------------
// slm_cell
// One window slot: holds a byte with its position, shifts it to the next
// cell on every item and checks the incoming byte against its term byte.
// ----------------------------------------------------------------------------
module slm_cell
   import slm_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  clear,
   input  logic [TERM_WIDTH-1:0] term,
   input  logic [LEN_WIDTH-1:0]  term_length,
   input  cell_link_type         link_in,
   output cell_link_type         link_out,
   output logic                  match_ok,
   output match_pos_type         match_pos
);

   localparam logic [6:0] CELL_POS = 7'(INDEX);

   cell_link_type         link_ff, link_in_d;
   logic                  active;
   logic [LEN_WIDTH-1:0]  k;
   logic                  is_start;

   // term byte compared here is term[len-1-INDEX]
   assign active   = CELL_POS < {2'b00, term_length};
   assign k        = term_length - LEN_WIDTH'(INDEX) - LEN_WIDTH'(1);
   assign is_start = active && (k == '0);

   assign match_ok = !active ||
                     (link_in.valid && (link_in.data_byte == term_byte(term, k)));

   always_comb begin
      match_pos = '0;
      if (is_start) begin
         match_pos.line   = link_in.line;
         match_pos.column = link_in.column;
      end
   end

   always_comb begin
      link_in_d = link_ff;
      if (shift_en) begin
         link_in_d = link_in;
      end
      if (clear) begin
         link_in_d.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in_d.valid;
      end
      link_ff.data_byte <= link_in_d.data_byte;
      link_ff.line      <= link_in_d.line;
      link_ff.column    <= link_in_d.column;
   end

   assign link_out = link_ff;

endmodule

@@ hdl/slm_rsp_buffer.sv @@
// ----------------------------------------------------------------------------
// slm_rsp_buffer
// Output register with a skid slot, so a single waiting result never stalls input.
// ----------------------------------------------------------------------------
module slm_rsp_buffer
   import slm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            space,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            pop;

   assign pop   = out_valid_ff && rsp_ready;
   assign space = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_data_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

@@ hdl/substring_match_locator.sv @@
// ----------------------------------------------------------------------------
// substring_match_locator
// Finds every occurrence of a search term in a byte stream and reports the
// line and column where each match starts.
// ----------------------------------------------------------------------------
// The block takes one file byte per item and accepts a new item every cycle
// unless input is held off. Each item that completes a match pushes a result
// into the output buffer; other items give no result. The window is a chain
// of MAX_TERM cells that shift on every item, each comparing the byte it is
// about to take against its term byte, so the match decision is one compare
// per cell and an and across the chain. A two-slot output buffer sits behind
// the chain, so input is only held off when two results are waiting. Line
// and column count from 1 and 0, saturate at all ones, and a newline belongs
// to the line it ends. An item with file_end set reports its own match (with
// match_last set) and then empties the window and restarts the counters.
// Term length 0 or above MAX_TERM never matches. Write the term registers
// only while the block is idle.
// ----------------------------------------------------------------------------
module substring_match_locator
   import slm_pkg::*;
#(
   parameter int unsigned MAX_TERM = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // byte items
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_payload,
   // match results
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_payload,
   // register writes
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata
);

   // config registers
   logic [LEN_WIDTH-1:0]   term_length_ff, term_length_in;
   logic [CSR_WIDTH-1:0]   term_low_ff, term_low_in;
   logic [CSR_WIDTH-1:0]   term_high_ff, term_high_in;
   logic [TERM_WIDTH-1:0]  term;

   // position of the next byte
   logic [COUNT_WIDTH-1:0] line_ff, line_in;
   logic [COUNT_WIDTH-1:0] column_ff, column_in;

   logic                   accept;
   logic                   hit;
   logic                   len_ok;
   logic                   buf_space;
   rsp_payload_type        result;
   match_pos_type          start_pos;

   cell_link_type          link_in  [MAX_TERM];
   cell_link_type          link_out [MAX_TERM];
   match_pos_type          cell_pos [MAX_TERM];
   logic [MAX_TERM-1:0]    cell_ok;

   assign accept = req_valid && req_ready;
   assign term   = {term_high_ff, term_low_ff};

   // register writes
   always_comb begin
      term_length_in = term_length_ff;
      term_low_in    = term_low_ff;
      term_high_in   = term_high_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TERM_LENGTH:     term_length_in = csr_wdata[LEN_WIDTH-1:0];
            CSR_TERM_BYTES_LOW:  term_low_in    = csr_wdata;
            CSR_TERM_BYTES_HIGH: term_high_in   = csr_wdata;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // line and column counters, saturating; newline ends its own line
   always_comb begin
      line_in   = line_ff;
      column_in = column_ff;
      if (accept) begin
         if (req_payload.file_end) begin
            line_in   = FIRST_LINE;
            column_in = '0;
         end else if (req_payload.data_byte == NEWLINE_BYTE) begin
            if (line_ff != COUNT_MAX) begin
               line_in = line_ff + COUNT_WIDTH'(1);
            end
            column_in = '0;
         end else if (column_ff != COUNT_MAX) begin
            column_in = column_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_length_ff <= LEN_RESET;
         term_low_ff    <= '0;
         term_high_ff   <= '0;
         line_ff        <= FIRST_LINE;
         column_ff      <= '0;
      end else begin
         term_length_ff <= term_length_in;
         term_low_ff    <= term_low_in;
         term_high_ff   <= term_high_in;
         line_ff        <= line_in;
         column_ff      <= column_in;
      end
   end

   // head of the chain takes the new byte with its position
   always_comb begin
      link_in[0].valid     = 1'b1;
      link_in[0].data_byte = req_payload.data_byte;
      link_in[0].line      = line_ff;
      link_in[0].column    = column_ff;
   end

   for (genvar j = 0; j < MAX_TERM; j++) begin : g_cell
      if (j > 0) begin : g_link
         assign link_in[j] = link_out[j-1];
      end
      slm_cell #(
         .INDEX (j)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (accept),
         .clear       (accept && req_payload.file_end),
         .term        (term),
         .term_length (term_length_ff),
         .link_in     (link_in[j]),
         .link_out    (link_out[j]),
         .match_ok    (cell_ok[j]),
         .match_pos   (cell_pos[j])
      );
   end

   // exactly one cell reports the start position when the length is legal
   always_comb begin
      start_pos = '0;
      for (int j = 0; j < MAX_TERM; j++) begin
         start_pos = start_pos | cell_pos[j];
      end
   end

   assign len_ok = (term_length_ff != '0) &&
                   ({2'b00, term_length_ff} <= 7'(MAX_TERM));
   assign hit    = len_ok && (&cell_ok);

   always_comb begin
      result.match_line   = start_pos.line;
      result.match_column = start_pos.column;
      result.match_last   = req_payload.file_end;
   end

   slm_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .push        (accept && hit),
      .push_data   (result),
      .space       (buf_space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assign req_ready = buf_space;

   // end of file restarts the position counters
   a_eof_restart : assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.file_end |=> line_ff == FIRST_LINE && column_ff == '0)
      else $error("position not restarted after end of file");

   // newline moves to the next line at column 0
   a_newline : assert property (@(posedge clock) disable iff (reset)
      accept && !req_payload.file_end && req_payload.data_byte == NEWLINE_BYTE
      && line_ff != COUNT_MAX
      |=> line_ff == $past(line_ff) + COUNT_WIDTH'(1) && column_ff == '0)
      else $error("newline did not advance the line");

   // input is only held off while a result waits at the output
   a_stall_has_result : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a match at the chain head always comes from a nonzero term length
   a_hit_len : assert property (@(posedge clock) disable iff (reset)
      accept && hit |-> term_length_ff != '0)
      else $error("match reported with zero term length");

endmodule
